FILE: rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants for the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int COORD_W  = 32;
  localparam int FRAC_DEF = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] t_entry;
    logic signed [COORD_W-1:0] t_exit;
    logic [1:0]                normal_axis;
    logic                      normal_positive;
  } result_t;

endpackage

FILE: rtl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, one quotient bit per stage, with signed
// saturation of the quotient in a final register stage.
// ----------------------------------------------------------------------------
module rbsi_div #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [rbsi_pkg::COORD_W-1:0]       num_mag,
  input  logic                               neg,
  input  logic [rbsi_pkg::COORD_W-1:0]       den,
  output logic signed [rbsi_pkg::COORD_W-1:0] quot
);
  import rbsi_pkg::*;

  localparam int CW = COORD_W;
  localparam int NW = CW + FRAC_BITS;
  localparam logic [NW-1:0] LIM_POS = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [NW-1:0] LIM_NEG = LIM_POS + 1'b1;
  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0] rem  [0:NW];
  logic [NW-1:0] numr [0:NW];
  logic [NW-1:0] quo  [0:NW];
  logic [CW-1:0] dv   [0:NW];
  logic          ng   [0:NW];

  assign rem[0]  = '0;
  assign numr[0] = {num_mag, {FRAC_BITS{1'b0}}};
  assign quo[0]  = '0;
  assign dv[0]   = den;
  assign ng[0]   = neg;

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;
    assign trial = {rem[i], numr[i][NW-1]};
    assign diff  = trial - {1'b0, dv[i]};
    assign ge    = trial >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? diff[CW-1:0] : trial[CW-1:0];
        numr[i+1] <= {numr[i][NW-2:0], 1'b0};
        quo[i+1]  <= {quo[i][NW-2:0], ge};
        dv[i+1]   <= dv[i];
        ng[i+1]   <= ng[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ng[NW]) begin
        quot <= (quo[NW] > LIM_NEG) ? T_MIN : -$signed(quo[NW][CW-1:0]);
      end else begin
        quot <= (quo[NW] > LIM_POS) ? T_MAX : $signed(quo[NW][CW-1:0]);
      end
    end
  end

endmodule

FILE: rtl/ray_box_slab_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top
// Slab test of a fixed point ray against one box held in APB registers.
// ----------------------------------------------------------------------------
//  channel  direction  signals
//  in       input      in_valid, in_stall, in_item (ray_t)
//  out      output     out_valid, out_stall, out_item (result_t)
//  cfg      APB slave  psel, penable, pwrite, paddr, pwdata, prdata, pready
//
//  One item per cycle while the output is not stalled; the depth is mostly set by the
//  six bit-per-stage dividers (one quotient bit each stage).
//  rst is synchronous and clears all valid bits and the box registers.
//  A stall while out_valid is high freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_top #(
  parameter int FRAC_BITS = rbsi_pkg::FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rbsi_pkg::ray_t                in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rbsi_pkg::result_t             out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbsi_pkg::APB_AW-1:0]   paddr,
  input  logic [rbsi_pkg::APB_DW-1:0]   pwdata,
  output logic [rbsi_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import rbsi_pkg::*;

  localparam int CW = COORD_W;
  localparam int NW = CW + FRAC_BITS;
  localparam int DL = NW + 1;
  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] box_min [0:2];
  logic signed [CW-1:0] box_max [0:2];
  reg_idx_t             widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        box_min[k] <= '0;
        box_max[k] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_MIN_X: box_min[0] <= pwdata;
        REG_MIN_Y: box_min[1] <= pwdata;
        REG_MIN_Z: box_min[2] <= pwdata;
        REG_MAX_X: box_max[0] <= pwdata;
        REG_MAX_Y: box_max[1] <= pwdata;
        REG_MAX_Z: box_max[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_MIN_X: prdata = box_min[0];
      REG_MIN_Y: prdata = box_min[1];
      REG_MIN_Z: prdata = box_min[2];
      REG_MAX_X: prdata = box_max[0];
      REG_MAX_Y: prdata = box_max[1];
      REG_MAX_Z: prdata = box_max[2];
      default:   prdata = '0;
    endcase
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // prep stage
  logic signed [CW-1:0] org [0:2];
  logic signed [CW-1:0] dir [0:2];
  assign org[0] = in_item.origin_x;
  assign org[1] = in_item.origin_y;
  assign org[2] = in_item.origin_z;
  assign dir[0] = in_item.dir_x;
  assign dir[1] = in_item.dir_y;
  assign dir[2] = in_item.dir_z;

  logic          v1;
  logic [CW-1:0] n_mag [0:2];
  logic          n_neg [0:2];
  logic [CW-1:0] f_mag [0:2];
  logic          f_neg [0:2];
  logic [CW-1:0] dmag  [0:2];
  logic          par1  [0:2];
  logic          ins1  [0:2];
  logic          dng1  [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_prep
    logic              dn;
    logic signed [CW:0] dlo, dhi, dnr, dfr;
    assign dn  = dir[a][CW-1];
    assign dlo = {box_min[a][CW-1], box_min[a]} - {org[a][CW-1], org[a]};
    assign dhi = {box_max[a][CW-1], box_max[a]} - {org[a][CW-1], org[a]};
    assign dnr = dn ? dhi : dlo;
    assign dfr = dn ? dlo : dhi;
    always_ff @(posedge clk) begin
      if (en) begin
        n_mag[a] <= dnr[CW] ? CW'(-dnr) : dnr[CW-1:0];
        n_neg[a] <= dnr[CW] ^ dn;
        f_mag[a] <= dfr[CW] ? CW'(-dfr) : dfr[CW-1:0];
        f_neg[a] <= dfr[CW] ^ dn;
        dmag[a]  <= dn ? -dir[a] : dir[a];
        dng1[a]  <= dn;
        par1[a]  <= (dir[a] == '0);
        ins1[a]  <= (box_min[a] <= org[a]) && (org[a] <= box_max[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  // dividers
  logic signed [CW-1:0] tn [0:2];
  logic signed [CW-1:0] tf [0:2];
  for (genvar a = 0; a < 3; a++) begin : g_div
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_near (
      .clk(clk), .en(en), .num_mag(n_mag[a]), .neg(n_neg[a]), .den(dmag[a]),
      .quot(tn[a])
    );
    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_far (
      .clk(clk), .en(en), .num_mag(f_mag[a]), .neg(f_neg[a]), .den(dmag[a]),
      .quot(tf[a])
    );
  end

  logic       vd  [0:DL];
  logic [2:0] pd  [0:DL];
  logic [2:0] id  [0:DL];
  logic [2:0] sd  [0:DL];
  assign vd[0] = v1;
  assign pd[0] = {par1[2], par1[1], par1[0]};
  assign id[0] = {ins1[2], ins1[1], ins1[0]};
  assign sd[0] = {dng1[2], dng1[1], dng1[0]};

  for (genvar i = 0; i < DL; i++) begin : g_meta
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[i+1] <= 1'b0;
      end else if (en) begin
        vd[i+1] <= vd[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pd[i+1] <= pd[i];
        id[i+1] <= id[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  // parallel override
  logic                 vq;
  logic signed [CW-1:0] qn [0:2];
  logic signed [CW-1:0] qf [0:2];
  logic [2:0]           qs;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (pd[DL][a]) begin
          qn[a] <= id[DL][a] ? T_MIN : T_MAX;
          qf[a] <= id[DL][a] ? T_MAX : T_MIN;
        end else begin
          qn[a] <= tn[a];
          qf[a] <= tf[a];
        end
      end
      qs <= sd[DL] & ~pd[DL];
    end
  end

  // entry and exit select
  logic                 vr;
  logic signed [CW-1:0] r_ent, r_ext;
  axis_t                r_ax;
  logic                 r_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      if (qn[2] > qn[1] && qn[2] > qn[0]) begin
        r_ent <= qn[2];
        r_ax  <= AXIS_Z;
        r_pos <= qs[2];
      end else if (qn[1] > qn[0]) begin
        r_ent <= qn[1];
        r_ax  <= AXIS_Y;
        r_pos <= qs[1];
      end else begin
        r_ent <= qn[0];
        r_ax  <= AXIS_X;
        r_pos <= qs[0];
      end
      if (qf[1] <= qf[0] && qf[1] <= qf[2]) begin
        r_ext <= qf[1];
      end else if (qf[2] <= qf[0]) begin
        r_ext <= qf[2];
      end else begin
        r_ext <= qf[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq        <= 1'b0;
      vr        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vq        <= vd[DL];
      vr        <= vq;
      out_valid <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.hit             <= (r_ent <= r_ext);
      out_item.t_entry         <= r_ent;
      out_item.t_exit          <= r_ext;
      out_item.normal_axis     <= r_ax;
      out_item.normal_positive <= r_pos;
    end
  end

endmodule

FILE: tb/rbsi_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rbsi_checker
// Watches the ray and result channels, predicts each slab test result from
// its own copy of the box corners, and compares field by field in order.
// ----------------------------------------------------------------------------
module rbsi_checker
  import rbsi_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  ray_t            in_item,
  input  logic            out_valid,
  input  logic            out_stall,
  input  result_t         out_item,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic            pready,
  output int              fail_count,
  output int              pending_count,
  output int              hit_count,
  output int              result_count
);

  localparam int FB = FRAC_DEF;
  localparam longint T_HI = 64'sd2147483647;
  localparam longint T_LO = -64'sd2147483648;

  logic signed [COORD_W-1:0] box_lo [3];
  logic signed [COORD_W-1:0] box_hi [3];
  result_t expected_results [$];

  function automatic longint slab_param(longint plane, longint org, longint dir);
    logic signed [127:0] num;
    logic signed [127:0] q;
    begin
      num = 128'(plane - org) <<< FB;
      q = num / 128'(dir);
      if (q > 128'(T_HI)) return T_HI;
      if (q < 128'(T_LO)) return T_LO;
      return longint'(q);
    end
  endfunction

  function automatic result_t predict_hit(ray_t r);
    longint o [3];
    longint d [3];
    longint nv, fv, entry, exitv;
    logic pos, positive;
    axis_t axis;
    result_t res;
    begin
      o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
      d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
      entry = 0; exitv = 0; positive = 0; axis = AXIS_X;
      for (int k = 0; k < 3; k++) begin
        if (d[k] == 0) begin
          if (longint'(box_lo[k]) <= o[k] && o[k] <= longint'(box_hi[k])) begin
            nv = T_LO; fv = T_HI;
          end else begin
            nv = T_HI; fv = T_LO;
          end
          pos = 1'b0;
        end else if (d[k] < 0) begin
          nv = slab_param(box_hi[k], o[k], d[k]);
          fv = slab_param(box_lo[k], o[k], d[k]);
          pos = 1'b1;
        end else begin
          nv = slab_param(box_lo[k], o[k], d[k]);
          fv = slab_param(box_hi[k], o[k], d[k]);
          pos = 1'b0;
        end
        if (k == 0) begin
          entry = nv; exitv = fv; positive = pos;
        end else begin
          if (nv > entry) begin
            entry = nv; axis = axis_t'(k); positive = pos;
          end
          if (fv < exitv) exitv = fv;
        end
      end
      res.hit = entry <= exitv;
      res.t_entry = entry[31:0];
      res.t_exit = exitv[31:0];
      res.normal_axis = axis;
      res.normal_positive = positive;
      return res;
    end
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        box_lo[k] <= '0;
        box_hi[k] <= '0;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_MIN_X: box_lo[0] <= pwdata;
          REG_MIN_Y: box_lo[1] <= pwdata;
          REG_MIN_Z: box_lo[2] <= pwdata;
          REG_MAX_X: box_hi[0] <= pwdata;
          REG_MAX_Y: box_hi[1] <= pwdata;
          REG_MAX_Z: box_hi[2] <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), predict_hit(in_item));
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.hit) hit_count++;
          if (out_item.hit !== exp_r.hit) begin
            $error("hit: expected %0d actual %0d", exp_r.hit, out_item.hit);
            fail_count++;
          end
          if (out_item.t_entry !== exp_r.t_entry) begin
            $error("t_entry: expected %0d actual %0d", exp_r.t_entry, out_item.t_entry);
            fail_count++;
          end
          if (out_item.t_exit !== exp_r.t_exit) begin
            $error("t_exit: expected %0d actual %0d", exp_r.t_exit, out_item.t_exit);
            fail_count++;
          end
          if (out_item.normal_axis !== exp_r.normal_axis) begin
            $error("normal_axis: expected %0d actual %0d", exp_r.normal_axis,
                   out_item.normal_axis);
            fail_count++;
          end
          if (out_item.normal_positive !== exp_r.normal_positive) begin
            $error("normal_positive: expected %0d actual %0d", exp_r.normal_positive,
                   out_item.normal_positive);
            fail_count++;
          end
        end
      end
    end
    pending_count <= expected_results.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
    hit_count = 0;
    result_count = 0;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives rays and box settings into the slab intersection block with random
// gaps and stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import rbsi_pkg::*;

  localparam int LATENCY = COORD_W + FRAC_DEF + 5;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  ray_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  result_t out_item;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  int fail_count, pending_count, hit_count, result_count;
  int rays_sent = 0;
  int idle_cycles = 0;
  bit long_hold = 0;

  ray_box_slab_intersect_top dut (.*);

  rbsi_checker checker_i (.*);

  initial forever #2 clk = ~clk;

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom();
      default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hffff_ffff;
      default: return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
    endcase
  endfunction

  task automatic write_box(reg_idx_t idx, logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= APB_AW'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_box(logic [31:0] lx, ly, lz, hx, hy, hz);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    write_box(REG_MIN_X, lx); write_box(REG_MIN_Y, ly); write_box(REG_MIN_Z, lz);
    write_box(REG_MAX_X, hx); write_box(REG_MAX_Y, hy); write_box(REG_MAX_Z, hz);
  endtask

  task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_item <= '{ox, oy, oz, dx, dy, dz};
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rays_sent++;
  endtask

  task automatic send_random(int n, bit gaps);
    for (int i = 0; i < n; i++)
      send_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
               rand_dir(), gaps && ($urandom_range(0, 3) != 0));
    in_valid <= 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_box(-(1 << 16), -(1 << 16), -(1 << 16), 1 << 16, 1 << 16, 1 << 16);
    send_ray(-(4 << 16), 0, 0, 1 << 16, 0, 0, 0);
    send_ray(4 << 16, 0, 0, -(1 << 16), 0, 0, 0);
    send_ray(0, -(4 << 16), 0, 0, 1 << 16, 0, 0);
    send_ray(0, 0, 4 << 16, 0, 0, -(1 << 16), 0);
    send_ray(0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 0);
    send_ray(-(4 << 16), -(4 << 16), 0, 1 << 16, 1 << 16, 0, 0);
    send_ray(0, 5 << 16, 0, 1 << 16, 0, 0, 0);
    send_ray(0, 1 << 16, 0, 1 << 16, 0, 0, 0);
    send_ray(0, 0, 0, 0, 0, 0, 0);
    send_ray(32'h8000_0000, 0, 0, 32'h0000_0001, 0, 0, 0);
    send_ray(32'h7fff_ffff, 0, 0, 32'hffff_ffff, 0, 0, 0);
    send_ray(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff, 1, 0);
    send_ray(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
             32'h7fff_ffff, 0);
    send_ray(-(4 << 16), 5 << 16, 0, 1 << 16, 0, 0, 0);
    in_valid <= 0;
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(32'h8000_0000, 32'h7fff_ffff, 0, 32'h0000_0001, 32'hffff_ffff, 0, 0);
    send_ray(32'h7fff_ffff, 32'h8000_0000, 0, 32'hffff_ffff, 32'h0000_0001, 0, 0);
    send_random(100, 1);
    set_box(1 << 16, 1 << 16, 1 << 16, -(1 << 16), -(1 << 16), -(1 << 16));
    send_random(100, 1);
    for (int phase = 0; phase < 6; phase++) begin
      set_box(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord());
      send_random(60, 1);
      set_box(-($urandom_range(0, 8) << 16), -($urandom_range(0, 8) << 16),
              -($urandom_range(0, 8) << 16), $urandom_range(0, 8) << 16,
              $urandom_range(0, 8) << 16, $urandom_range(0, 8) << 16);
      if (phase == 2) long_hold = 1;
      send_random(40, phase != 2);
      send_random(40, 0);
      long_hold = 0;
    end
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("tb: %0d rays, %0d results checked, %0d hits, several box settings",
             rays_sent, result_count, hit_count);
    if (fail_count == 0 && pending_count == 0)
      $display("** ray_box_slab_intersect_top: PASSED **");
    else
      $display("** ray_box_slab_intersect_top: FAILED **");
    $finish;
  end

  initial begin
    int stall_len;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        out_stall <= 0;
        while (long_hold) @(posedge clk);
      end else begin
        stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        if (stall_len != 0) begin
          out_stall <= 1;
          repeat (stall_len) @(posedge clk);
        end
        out_stall <= 0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("** ray_box_slab_intersect_top: FAILED **");
      $finish;
    end
  end

endmodule
